[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl
// each takes a label, a condition and a consequence, sampled on clk, off in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, cond, cons)
`define ASSERT_NEXT(lbl, cond, cons)
`endif
`endif

[rtl/core/tsh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tsh_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_ERROR = 2'd2
  } phase_t;

  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SETPOINT   = 2'd0,
    CFG_HYSTERESIS = 2'd1,
    CFG_PERIOD     = 2'd2,
    CFG_TIMEOUT    = 2'd3
  } cfg_idx_t;

  localparam int SETPOINT_RST   = 320;
  localparam int HYSTERESIS_RST = 8;
  localparam int PERIOD_RST     = 50;
  localparam int TIMEOUT_RST    = 10;

endpackage
`default_nettype wire

[rtl/core/thermostat_sampler_hysteresis.sv]
`timescale 1ns / 1ps
`default_nettype none
// sampling thermostat with hysteresis, one input word per tick
// in_*  : tick words (sensor ready flag and Q12.4 reading), taken on tvalid && tready
// out_* : one result word per tick word, in order: start, taken, timeout flags,
//         load state, reader phase and the last captured temperature
// cfg_* : register writes at any edge with cfg_we high; the user must write only while the block is idle,
//         which the block itself does not enforce; index 0 setpoint, 1 hysteresis, 2 sample period, 3 timeout
// the result word is registered when its tick word is accepted and is valid in the cycle after
// throughput: one word per cycle while out_tready is high; the reader state update
//   is a single step of logic between the input port and the result register
// a new word is accepted while the current result is taken in the same cycle,
//   so a stalled receiver holds the result and stops the input side with it
// reset (synchronous, rst_n low): registers return to setpoint 320, hysteresis 8,
//   period 50, timeout 10; reader idle, load off, held temperature all ones,
//   no result pending
module thermostat_sampler_hysteresis #(
  parameter int TEMP_BITS  = 16,
  parameter int COUNT_BITS = 8
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // tdata fields from bit 0: sensor_ready, sensor_temperature
  input  wire [((TEMP_BITS+8)/8)*8-1:0]        in_tdata,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // tdata fields from bit 0: start_conversion, reading_taken, timeout_error,
  // load_on, phase, held_temperature
  output logic [((TEMP_BITS+13)/8)*8-1:0]      out_tdata,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  input  wire                                  cfg_we,
  input  wire [tsh_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire [((TEMP_BITS > COUNT_BITS) ? TEMP_BITS : COUNT_BITS)-1:0] cfg_data
);

  localparam int OUT_W = ((TEMP_BITS + 13) / 8) * 8;
  localparam int HYST_BITS = TEMP_BITS - 1;

  logic signed [TEMP_BITS-1:0] setpoint_r;
  logic [HYST_BITS-1:0]        hyst_r;
  logic [COUNT_BITS-1:0]       period_r;
  logic [COUNT_BITS-1:0]       timeout_r;

  logic [COUNT_BITS-1:0]       tick_r, tick_nxt;
  logic [COUNT_BITS-1:0]       wait_r, wait_nxt;
  tsh_pkg::phase_t             phase_r, phase_nxt;
  logic                        load_r, load_nxt;
  logic [TEMP_BITS-1:0]        stored_r, stored_nxt;

  logic start_r, start_nxt;
  logic taken_r, taken_nxt;
  logic tmo_r, tmo_nxt;
  logic out_valid_r;

  logic                        accept;
  logic                        ready_in;
  logic [TEMP_BITS-1:0]        temp_in;
  logic [COUNT_BITS-1:0]       tick_inc;
  logic [COUNT_BITS-1:0]       wait_dec;
  logic                        period_hit;
  logic signed [TEMP_BITS:0]   sp_ext;
  logic signed [TEMP_BITS:0]   low_ext;
  logic signed [TEMP_BITS:0]   t_ext;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign ready_in  = in_tdata[0];
  assign temp_in   = in_tdata[TEMP_BITS:1];

  // saturating sample counter, never passes the period
  assign tick_inc   = (tick_r < period_r) ? tick_r + 1'b1 : tick_r;
  assign period_hit = (tick_inc >= period_r);
  assign wait_dec   = wait_r - 1'b1;

  // next reader phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      tsh_pkg::PH_IDLE: begin
        if (period_hit) phase_nxt = tsh_pkg::PH_WAIT;
      end
      tsh_pkg::PH_WAIT: begin
        if (ready_in) begin
          phase_nxt = tsh_pkg::PH_IDLE;
        end else if (wait_dec == '0) begin
          phase_nxt = tsh_pkg::PH_ERROR;
        end
      end
      default: phase_nxt = tsh_pkg::PH_IDLE;
    endcase
  end

  // counters, flags and capture for this tick
  always_comb begin
    tick_nxt   = tick_inc;
    wait_nxt   = wait_r;
    stored_nxt = stored_r;
    start_nxt  = 1'b0;
    taken_nxt  = 1'b0;
    tmo_nxt    = 1'b0;
    case (phase_r)
      tsh_pkg::PH_IDLE: begin
        if (period_hit) begin
          tick_nxt  = '0;
          wait_nxt  = timeout_r;
          start_nxt = 1'b1;
        end
      end
      tsh_pkg::PH_WAIT: begin
        if (ready_in) begin
          stored_nxt = temp_in;
          taken_nxt  = 1'b1;
        end else begin
          wait_nxt = wait_dec;
          tmo_nxt  = (wait_dec == '0);
        end
      end
      default: ;
    endcase
  end

  // hysteresis compare one bit wider than the reading
  assign sp_ext  = {setpoint_r[TEMP_BITS-1], setpoint_r};
  assign low_ext = sp_ext - $signed({2'b00, hyst_r});
  assign t_ext   = $signed({temp_in[TEMP_BITS-1], temp_in});

  always_comb begin
    load_nxt = load_r;
    if (taken_nxt) begin
      if (t_ext <= low_ext) begin
        load_nxt = 1'b1;
      end else if (t_ext >= sp_ext) begin
        load_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= TEMP_BITS'(tsh_pkg::SETPOINT_RST);
      hyst_r     <= HYST_BITS'(tsh_pkg::HYSTERESIS_RST);
      period_r   <= COUNT_BITS'(tsh_pkg::PERIOD_RST);
      timeout_r  <= COUNT_BITS'(tsh_pkg::TIMEOUT_RST);
    end else if (cfg_we) begin
      case (tsh_pkg::cfg_idx_t'(cfg_index))
        tsh_pkg::CFG_SETPOINT:   setpoint_r <= cfg_data[TEMP_BITS-1:0];
        tsh_pkg::CFG_HYSTERESIS: hyst_r     <= cfg_data[HYST_BITS-1:0];
        tsh_pkg::CFG_PERIOD:     period_r   <= cfg_data[COUNT_BITS-1:0];
        tsh_pkg::CFG_TIMEOUT:    timeout_r  <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      wait_r      <= '0;
      phase_r     <= tsh_pkg::PH_IDLE;
      load_r      <= 1'b0;
      stored_r    <= '1;
      start_r     <= 1'b0;
      taken_r     <= 1'b0;
      tmo_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        tick_r   <= tick_nxt;
        wait_r   <= wait_nxt;
        phase_r  <= phase_nxt;
        load_r   <= load_nxt;
        stored_r <= stored_nxt;
        start_r  <= start_nxt;
        taken_r  <= taken_nxt;
        tmo_r    <= tmo_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // state registers only move on accept, so they match the pending word
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({stored_r, phase_r, load_r, tmo_r, taken_r, start_r});

`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_flags_exclusive, out_valid_r, $onehot0({start_r, taken_r, tmo_r}))
  `ASSERT_IMPLIES(a_start_waits, out_valid_r && start_r, phase_r == tsh_pkg::PH_WAIT)
  `ASSERT_IMPLIES(a_taken_idle, out_valid_r && taken_r, phase_r == tsh_pkg::PH_IDLE)
  `ASSERT_IMPLIES(a_tmo_error, out_valid_r && tmo_r, phase_r == tsh_pkg::PH_ERROR)
  `ASSERT_NEXT(a_error_one_tick, accept && phase_r == tsh_pkg::PH_ERROR,
               phase_r == tsh_pkg::PH_IDLE)

endmodule
`default_nettype wire
